### hdl/transfer_switch_sequencer_macros.svh
// Assertion macros used by the transfer switch sequencer core
`ifndef TRANSFER_SWITCH_SEQUENCER_MACROS_SVH
`define TRANSFER_SWITCH_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define TSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define TSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tss_pkg.sv
// Package: beat types, register map, mode codes and beep lengths
`timescale 1ns / 1ps

package tss_pkg;

  localparam int CFG_W   = 8;
  localparam int CIDX_W  = 3;
  localparam int BEEP_W  = 10;
  localparam int MODE_W  = 4;
  localparam int SECS_W  = 8;

  typedef struct packed {
    logic mains_present;
    logic gen_running;
  } in_t;

  typedef struct packed {
    logic              mains_relay;
    logic              genset_relay;
    logic              starter_relay;
    logic              buzzer_level;
    logic [BEEP_W-1:0] beep_ms;
    logic              switch_pause;
    logic [MODE_W-1:0] mode;
    logic [SECS_W-1:0] seconds_left;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0] mains_fail_delay;
    logic [CFG_W-1:0] crank_time;
    logic [CFG_W-1:0] warmup_time;
    logic [CFG_W-1:0] mains_return_delay;
    logic [CFG_W-1:0] cooldown_time;
  } cfg_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MAINS_FAIL_DELAY   = 3'd0,
    CFG_CRANK_TIME         = 3'd1,
    CFG_WARMUP_TIME        = 3'd2,
    CFG_MAINS_RETURN_DELAY = 3'd3,
    CFG_COOLDOWN_TIME      = 3'd4
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] RST_MAINS_FAIL_DELAY   = 8'd3;
  localparam logic [CFG_W-1:0] RST_CRANK_TIME         = 8'd7;
  localparam logic [CFG_W-1:0] RST_WARMUP_TIME        = 8'd10;
  localparam logic [CFG_W-1:0] RST_MAINS_RETURN_DELAY = 8'd15;
  localparam logic [CFG_W-1:0] RST_COOLDOWN_TIME      = 8'd30;

  localparam logic [BEEP_W-1:0] BEEP_NONE     = 10'd0;
  localparam logic [BEEP_W-1:0] BEEP_MAINS_LOST = 10'd500;
  localparam logic [BEEP_W-1:0] BEEP_ON_GEN   = 10'd100;
  localparam logic [BEEP_W-1:0] BEEP_RUN_FAIL = 10'd1000;
  localparam logic [BEEP_W-1:0] BEEP_MAINS_BACK = 10'd150;
  localparam logic [BEEP_W-1:0] BEEP_MAINS_DROP = 10'd300;
  localparam logic [BEEP_W-1:0] BEEP_RECOVER  = 10'd250;

  typedef enum logic [8:0] {
    M_ON_MAINS   = 9'b000000001,
    M_FAILED     = 9'b000000010,
    M_CRANK      = 9'b000000100,
    M_WARM       = 9'b000001000,
    M_ON_GEN     = 9'b000010000,
    M_RETURNED   = 9'b000100000,
    M_COOL       = 9'b001000000,
    M_START_FAIL = 9'b010000000,
    M_RUN_FAIL   = 9'b100000000
  } mode_t;

  localparam logic [MODE_W-1:0] MODE_ON_MAINS   = 4'd0;
  localparam logic [MODE_W-1:0] MODE_FAILED     = 4'd1;
  localparam logic [MODE_W-1:0] MODE_CRANK      = 4'd2;
  localparam logic [MODE_W-1:0] MODE_WARM       = 4'd3;
  localparam logic [MODE_W-1:0] MODE_ON_GEN     = 4'd4;
  localparam logic [MODE_W-1:0] MODE_RETURNED   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_COOL       = 4'd6;
  localparam logic [MODE_W-1:0] MODE_START_FAIL = 4'd7;
  localparam logic [MODE_W-1:0] MODE_RUN_FAIL   = 4'd8;

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] c;
    case (m)
      M_ON_MAINS:   c = MODE_ON_MAINS;
      M_FAILED:     c = MODE_FAILED;
      M_CRANK:      c = MODE_CRANK;
      M_WARM:       c = MODE_WARM;
      M_ON_GEN:     c = MODE_ON_GEN;
      M_RETURNED:   c = MODE_RETURNED;
      M_COOL:       c = MODE_COOL;
      M_START_FAIL: c = MODE_START_FAIL;
      M_RUN_FAIL:   c = MODE_RUN_FAIL;
      default:      c = MODE_ON_MAINS;
    endcase
    return c;
  endfunction

endpackage

### hdl/tss_cfg.sv
// Delay register file written through the configuration channel
`timescale 1ns / 1ps

module tss_cfg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [tss_pkg::CIDX_W-1:0] cfg_index,
  input  logic [tss_pkg::CFG_W-1:0]  cfg_data,
  output tss_pkg::cfg_t            regs
);
  import tss_pkg::*;

  assign cfg_ready = 1'b1;

  // Writes beyond the last register fall through and are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mains_fail_delay   <= RST_MAINS_FAIL_DELAY;
      regs.crank_time         <= RST_CRANK_TIME;
      regs.warmup_time        <= RST_WARMUP_TIME;
      regs.mains_return_delay <= RST_MAINS_RETURN_DELAY;
      regs.cooldown_time      <= RST_COOLDOWN_TIME;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAINS_FAIL_DELAY:   regs.mains_fail_delay   <= cfg_data;
        CFG_CRANK_TIME:         regs.crank_time         <= cfg_data;
        CFG_WARMUP_TIME:        regs.warmup_time        <= cfg_data;
        CFG_MAINS_RETURN_DELAY: regs.mains_return_delay <= cfg_data;
        CFG_COOLDOWN_TIME:      regs.cooldown_time      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

### hdl/tss_core.sv
// Mode sequencer: state registers and the per-tick next-state logic
`timescale 1ns / 1ps
`include "transfer_switch_sequencer_macros.svh"

module tss_core #(
  parameter int TIMER_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  tss_pkg::in_t  tick,
  input  tss_pkg::cfg_t regs,
  output tss_pkg::out_t result
);
  import tss_pkg::*;

  localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] TMR_MAX = '1;

  mode_t                 mode_reg, mode_next;
  logic [TIMER_BITS-1:0] countdown, countdown_next;
  logic [2:0]            relay_bits, relay_bits_next;
  logic                  buzzer_bit, buzzer_bit_next;

  logic [TIMER_BITS-1:0] cd_load;
  logic [BEEP_W-1:0]     beep;
  logic                  pause;
  logic [CW-1:0]         cd_ext;

  // Saturate a delay register to what the countdown can hold
  function automatic logic [TIMER_BITS-1:0] load_time(input logic [CFG_W-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    if (e > CW'(TMR_MAX)) e = CW'(TMR_MAX);
    return TIMER_BITS'(e);
  endfunction

  always_comb begin
    mode_next       = mode_reg;
    cd_load         = countdown;
    relay_bits_next = relay_bits;
    buzzer_bit_next = buzzer_bit;
    beep            = BEEP_NONE;
    pause           = 1'b0;
    case (mode_reg)
      M_ON_MAINS: begin
        relay_bits_next = 3'b001;
        if (!tick.mains_present) begin
          mode_next = M_FAILED;
          cd_load   = load_time(regs.mains_fail_delay);
          beep      = BEEP_MAINS_LOST;
        end
      end
      M_FAILED: begin
        relay_bits_next[0] = 1'b0;
        if (countdown == '0) begin
          mode_next = M_CRANK;
          cd_load   = load_time(regs.crank_time);
        end
        // mains back overrides, the crank load still stands
        if (tick.mains_present) mode_next = M_ON_MAINS;
      end
      M_CRANK: begin
        relay_bits_next[2] = 1'b1;
        if (tick.gen_running) begin
          relay_bits_next[2] = 1'b0;
          mode_next = M_WARM;
          cd_load   = load_time(regs.warmup_time);
        end else if (countdown == '0) begin
          relay_bits_next[2] = 1'b0;
          mode_next = M_START_FAIL;
        end
      end
      M_WARM: begin
        if (countdown == '0) begin
          mode_next = M_ON_GEN;
          beep      = BEEP_ON_GEN;
        end
      end
      M_ON_GEN: begin
        relay_bits_next[1] = 1'b1;
        relay_bits_next[0] = 1'b0;
        if (!tick.gen_running) begin
          relay_bits_next[1] = 1'b0;
          beep      = BEEP_RUN_FAIL;
          mode_next = M_RUN_FAIL;
        end else if (tick.mains_present) begin
          mode_next = M_RETURNED;
          cd_load   = load_time(regs.mains_return_delay);
          beep      = BEEP_MAINS_BACK;
        end
      end
      M_RETURNED: begin
        if (countdown == '0) begin
          relay_bits_next[1] = 1'b0;
          relay_bits_next[0] = 1'b1;
          pause     = 1'b1;
          mode_next = M_COOL;
          cd_load   = load_time(regs.cooldown_time);
        end
        // transfer still happens if mains drops on the same tick
        if (!tick.mains_present) mode_next = M_ON_GEN;
      end
      M_COOL: begin
        if (!tick.mains_present) begin
          beep               = BEEP_MAINS_DROP;
          relay_bits_next[0] = 1'b0;
          relay_bits_next[1] = 1'b1;
          pause              = 1'b1;
          mode_next          = M_ON_GEN;
        end else if (countdown == '0) begin
          mode_next = M_ON_MAINS;
        end
      end
      M_START_FAIL, M_RUN_FAIL: begin
        if (tick.mains_present) begin
          buzzer_bit_next = 1'b0;
          beep            = BEEP_RECOVER;
          mode_next       = M_ON_MAINS;
        end else begin
          relay_bits_next = 3'b000;
          buzzer_bit_next = ~buzzer_bit;
        end
      end
      default: mode_next = M_ON_MAINS;
    endcase

    if (beep != BEEP_NONE) buzzer_bit_next = 1'b0;
    countdown_next = (cd_load != '0) ? cd_load - TIMER_BITS'(1) : cd_load;
  end

  assign cd_ext = CW'(countdown_next);

  always_comb begin
    result.mains_relay   = relay_bits_next[0];
    result.genset_relay  = relay_bits_next[1];
    result.starter_relay = relay_bits_next[2];
    result.buzzer_level  = buzzer_bit_next;
    result.beep_ms       = beep;
    result.switch_pause  = pause;
    result.mode          = mode_code(mode_next);
    result.seconds_left  = cd_ext[SECS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg   <= M_ON_MAINS;
      countdown  <= '0;
      relay_bits <= 3'b000;
      buzzer_bit <= 1'b0;
    end else if (step) begin
      mode_reg   <= mode_next;
      countdown  <= countdown_next;
      relay_bits <= relay_bits_next;
      buzzer_bit <= buzzer_bit_next;
    end
  end

  `TSS_ASSERT_NOW(a_contactor_interlock, clk, rst, 1'b1,
    !(relay_bits[0] && relay_bits[1]),
    "mains and generator contactors closed together")
  `TSS_ASSERT_NEXT(a_fail_opens_all, clk, rst,
    step && (mode_reg == M_START_FAIL || mode_reg == M_RUN_FAIL) && !tick.mains_present,
    relay_bits == 3'b000, "relays not opened in a failure mode")
  `TSS_ASSERT_NEXT(a_warm_counts_down, clk, rst, step && mode_reg == M_WARM && countdown != '0,
    countdown == $past(countdown) - TIMER_BITS'(1), "warm-up countdown did not advance by one")
  `TSS_ASSERT_NEXT(a_hold_without_tick, clk, rst, !step,
    $stable(mode_reg) && $stable(countdown) && $stable(relay_bits),
    "sequencer state moved without a tick")

endmodule

### hdl/transfer_switch_sequencer.sv
// Top level: input register, sequencer, delay registers and result register
`timescale 1ns / 1ps

//  channel   signals                          direction  beat taken when
//  in        in_valid, in_stall, in_data      sink       in_valid && !in_stall
//  out       out_valid, out_stall, out_data   source     out_valid && !out_stall
//  cfg       cfg_valid, cfg_ready, cfg_index, sink       cfg_valid && cfg_ready
//            cfg_data
//
// A tick beat is registered in the input register, and the sequencer updates its
// state as the beat moves into the result register. One beat per cycle is sustained
// while out_stall is low, the mode update being the only loop.
// Synchronous reset returns to on-mains with relays open and the reset delays.
// Output stall holds the result register and stalls the input only once the input
// register is also full. cfg_ready is always high.

module transfer_switch_sequencer #(
  parameter int TIMER_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  tss_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tss_pkg::out_t              out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tss_pkg::CIDX_W-1:0] cfg_index,
  input  logic [tss_pkg::CFG_W-1:0]  cfg_data
);
  import tss_pkg::*;

  logic  hold_valid;
  in_t   hold_data;
  logic  advance;
  logic  step;
  cfg_t  regs;
  out_t  result;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = hold_valid && !advance;
  assign step     = hold_valid && advance;

  tss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  tss_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .tick   (hold_data),
    .regs   (regs),
    .result (result)
  );

  // Refill the input register whenever it empties or moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!hold_valid || advance) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!hold_valid || advance) && in_valid) begin
      hold_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule
